>>> rtl/core/jsu_pkg.sv
// ----------------------------------------------------------------------------
// JSON string unescape package
// Beat types, decode mode codes and error codes shared by the unescape core.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

    // One input beat: a raw byte of the string body, or the end of the stream.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } t_in_beat;

    // One result beat.
    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_value;
        logic       string_done;
        logic [2:0] error_code;
    } t_out_beat;

    // Decode modes: normal, after backslash, and the four hex digit slots.
    localparam logic [2:0] MODE_NORMAL    = 3'd0;
    localparam logic [2:0] MODE_ESCAPE    = 3'd1;
    localparam logic [2:0] MODE_HEX_FIRST = 3'd2;
    localparam logic [2:0] MODE_HEX_LAST  = 3'd5;

    // Error codes.
    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_BAD_ESCAPE   = 3'd1;
    localparam logic [2:0] ERR_BAD_HEX      = 3'd2;
    localparam logic [2:0] ERR_NON_ASCII    = 3'd3;
    localparam logic [2:0] ERR_UNTERMINATED = 3'd4;

    // Characters of interest.
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_FORMFEED  = 8'h0C;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;

endpackage

`default_nettype wire

>>> rtl/core/jsu_decode.sv
// ----------------------------------------------------------------------------
// JSON string unescape decoder
// Holds the decode mode and hex accumulator and forms the result for one beat.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_decode
    import jsu_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_fire,
    input  wire t_in_beat  i_item,
    output      t_out_beat o_result
);

    logic [2:0]  r_mode;
    logic [2:0]  n_mode;
    logic [15:0] r_acc;
    logic [15:0] n_acc;
    logic [3:0]  hex_val;
    logic        hex_ok;
    logic [15:0] acc_shift;
    t_out_beat   res;

    // Hex digit value; hex_ok is low when the byte is not a hex digit.
    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (i_item.in_byte >= 8'h30 && i_item.in_byte <= 8'h39) begin
            hex_val = 4'(i_item.in_byte - 8'h30);
        end else if (i_item.in_byte >= 8'h41 && i_item.in_byte <= 8'h46) begin
            hex_val = 4'(i_item.in_byte - 8'h37);
        end else if (i_item.in_byte >= 8'h61 && i_item.in_byte <= 8'h66) begin
            hex_val = 4'(i_item.in_byte - 8'h57);
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign acc_shift = {r_acc[11:0], hex_val};

    // Next mode, next accumulator and the result for the current beat.
    always_comb begin
        n_mode = MODE_NORMAL;
        n_acc  = 16'd0;
        res    = '{char_valid: 1'b0, char_value: 8'd0, string_done: 1'b0,
                   error_code: ERR_NONE};
        if (i_item.stream_end) begin
            res.error_code = ERR_UNTERMINATED;
        end else begin
            case (r_mode) inside
                MODE_ESCAPE: begin
                    res.char_valid = 1'b1;
                    case (i_item.in_byte) inside
                        CH_QUOTE, CH_BACKSLASH, CH_SLASH: res.char_value = i_item.in_byte;
                        CH_B: res.char_value = CH_BACKSPACE;
                        CH_F: res.char_value = CH_FORMFEED;
                        CH_N: res.char_value = CH_NEWLINE;
                        CH_R: res.char_value = CH_RETURN;
                        CH_T: res.char_value = CH_TAB;
                        CH_U: begin
                            res.char_valid = 1'b0;
                            n_mode         = MODE_HEX_FIRST;
                        end
                        default: begin
                            res.char_valid = 1'b0;
                            res.error_code = ERR_BAD_ESCAPE;
                        end
                    endcase
                end
                [MODE_HEX_FIRST:MODE_HEX_LAST]: begin
                    if (!hex_ok) begin
                        res.error_code = ERR_BAD_HEX;
                    end else if (r_mode != MODE_HEX_LAST) begin
                        n_mode = r_mode + 3'd1;
                        n_acc  = acc_shift;
                    end else if (acc_shift[15:7] != 9'd0) begin
                        res.error_code = ERR_NON_ASCII;
                    end else begin
                        res.char_valid = 1'b1;
                        res.char_value = acc_shift[7:0];
                    end
                end
                default: begin
                    // Normal mode; unused mode codes behave the same way.
                    if (i_item.in_byte == CH_QUOTE) begin
                        res.string_done = 1'b1;
                    end else if (i_item.in_byte == CH_BACKSLASH) begin
                        n_mode = MODE_ESCAPE;
                        n_acc  = r_acc;
                    end else begin
                        res.char_valid = 1'b1;
                        res.char_value = i_item.in_byte;
                    end
                end
            endcase
        end
    end

    assign o_result = res;

    // State advances once per decoded beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_acc  <= 16'd0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
        end
    end

    // Stream end always leaves the decoder in a clean normal state.
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.stream_end |=> r_mode == MODE_NORMAL && r_acc == 16'd0)
        else $error("stream end did not clear decode state");

    // A character and an error or a done never come in the same beat.
    a_excl_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_result.char_valid |->
            o_result.error_code == ERR_NONE && !o_result.string_done)
        else $error("character beat also flags done or error");

    // The accumulator starts empty at the first hex digit.
    a_hex_first_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_HEX_FIRST |-> r_acc == 16'd0)
        else $error("accumulator not clear at first hex digit");

endmodule

`default_nettype wire

>>> rtl/core/json_string_unescape.sv
// An accepted beat goes into the input register, its result into the result
// register. Throughput: one byte per cycle unless the output stalls; the
// decoder only steps as a result loads, so it holds its state across stalls.
// Decoding is one short combinational pass between the two registers.
// Reset is synchronous, active low: both registers empty, decoder in normal
// mode with the hex accumulator cleared.
// ----------------------------------------------------------------------------
// JSON string unescape top level
// Input register, decoder and result register with valid/stall beats.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape
    import jsu_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output      logic      o_in_stall,
    input  wire t_in_beat  i_in_data,
    output      logic      o_out_valid,
    input  wire logic      i_out_stall,
    output      t_out_beat o_out_data
);

    logic      r_in_valid;
    t_in_beat  r_in_data;
    logic      r_out_valid;
    t_out_beat r_out_data;
    t_out_beat dec_result;
    logic      out_load;
    logic      advance;

    // The result register takes a new beat when empty or being drained.
    assign out_load   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_load;
    assign o_in_stall = r_in_valid && !out_load;

    jsu_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in_data),
        .o_result (dec_result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_data <= i_in_data;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= dec_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// JSON string unescape testbench
// Streams string bodies, escapes, broken escapes and early stream ends into
// the core and checks every result beat against a byte-level decoder model.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import jsu_pkg::*;

    // Decoder model and queue of expected result beats.
    class char_scoreboard;
        logic [2:0]  mode;
        logic [15:0] hex_acc;
        t_out_beat   expected_chars[$];
        int          failures;

        function new();
            mode     = MODE_NORMAL;
            hex_acc  = '0;
            failures = 0;
        endfunction

        // Value of a hex digit, with bit 4 set when the byte is not one.
        function logic [4:0] hex_nibble(logic [7:0] b);
            if (b >= 8'h30 && b <= 8'h39) return {1'b0, 4'(b - 8'h30)};
            if (b >= 8'h41 && b <= 8'h46) return {1'b0, 4'(b - 8'h41 + 8'd10)};
            if (b >= 8'h61 && b <= 8'h66) return {1'b0, 4'(b - 8'h61 + 8'd10)};
            return 5'h10;
        endfunction

        // Work out the result of one accepted input beat.
        function void predict_char(t_in_beat beat);
            t_out_beat  res;
            logic [4:0] nib;
            res = '0;
            if (beat.stream_end) begin
                mode           = MODE_NORMAL;
                hex_acc        = '0;
                res.error_code = ERR_UNTERMINATED;
            end else if (mode == MODE_ESCAPE) begin
                mode           = MODE_NORMAL;
                res.char_valid = 1'b1;
                case (beat.in_byte)
                    CH_QUOTE, CH_BACKSLASH, CH_SLASH: res.char_value = beat.in_byte;
                    CH_B: res.char_value = CH_BACKSPACE;
                    CH_F: res.char_value = CH_FORMFEED;
                    CH_N: res.char_value = CH_NEWLINE;
                    CH_R: res.char_value = CH_RETURN;
                    CH_T: res.char_value = CH_TAB;
                    CH_U: begin
                        res.char_valid = 1'b0;
                        mode           = MODE_HEX_FIRST;
                        hex_acc        = '0;
                    end
                    default: begin
                        res.char_valid = 1'b0;
                        hex_acc        = '0;
                        res.error_code = ERR_BAD_ESCAPE;
                    end
                endcase
            end else if (mode >= MODE_HEX_FIRST && mode <= MODE_HEX_LAST) begin
                nib = hex_nibble(beat.in_byte);
                if (nib[4]) begin
                    mode           = MODE_NORMAL;
                    hex_acc        = '0;
                    res.error_code = ERR_BAD_HEX;
                end else begin
                    hex_acc = {hex_acc[11:0], nib[3:0]};
                    if (mode != MODE_HEX_LAST) begin
                        mode = 3'(mode + 3'd1);
                    end else begin
                        // Last digit: only plain ASCII values are accepted.
                        if (hex_acc >= 16'h0080) begin
                            res.error_code = ERR_NON_ASCII;
                        end else begin
                            res.char_valid = 1'b1;
                            res.char_value = hex_acc[7:0];
                        end
                        mode    = MODE_NORMAL;
                        hex_acc = '0;
                    end
                end
            end else begin
                mode = MODE_NORMAL;
                if (beat.in_byte == CH_QUOTE) begin
                    hex_acc         = '0;
                    res.string_done = 1'b1;
                end else if (beat.in_byte == CH_BACKSLASH) begin
                    mode = MODE_ESCAPE;
                end else begin
                    res.char_valid = 1'b1;
                    res.char_value = beat.in_byte;
                end
            end
            expected_chars = {expected_chars, res};
        endfunction

        // Compare one accepted result beat with the oldest expectation.
        function void check_char(t_out_beat got);
            t_out_beat exp_beat;
            if (expected_chars.size() == 0) begin
                $error("result beat with no expected result waiting: %h", got);
                failures++;
                return;
            end
            exp_beat = expected_chars.pop_front();
            if (got.char_valid !== exp_beat.char_valid) begin
                $error("char_valid: expected %0d, actual %0d",
                       exp_beat.char_valid, got.char_valid);
                failures++;
            end
            if (got.char_value !== exp_beat.char_value) begin
                $error("char_value: expected 0x%02h, actual 0x%02h",
                       exp_beat.char_value, got.char_value);
                failures++;
            end
            if (got.string_done !== exp_beat.string_done) begin
                $error("string_done: expected %0d, actual %0d",
                       exp_beat.string_done, got.string_done);
                failures++;
            end
            if (got.error_code !== exp_beat.error_code) begin
                $error("error_code: expected %0d, actual %0d",
                       exp_beat.error_code, got.error_code);
                failures++;
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_beat  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_beat o_out_data;

    char_scoreboard sb = new();
    int             send_gap_pct;
    int             stall_pct;
    int             beats_sent;

    localparam logic [7:0] ESCAPE_LETTERS [8] = '{
        CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T
    };

    json_string_unescape uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Clock with a period of 4.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Every accepted input beat feeds the model.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            sb.predict_char(i_in_data);
        end
    end

    // Result side: check accepted beats and stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_char(o_out_data);
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Offer one beat, after random idle cycles, and hold it until accepted.
    task automatic send_beat(input t_in_beat beat);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_in_beat beat;
        beat.in_byte    = b;
        beat.stream_end = 1'b0;
        send_beat(beat);
    endtask

    // End of stream; the byte lane carries random junk.
    task automatic send_stream_end();
        t_in_beat beat;
        beat.in_byte    = 8'($urandom_range(255));
        beat.stream_end = 1'b1;
        send_beat(beat);
    endtask

    // Hex digit character with random letter case.
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    // Send a complete unicode escape for the given value.
    task automatic send_hex_escape(input logic [15:0] value);
        send_byte(CH_BACKSLASH);
        send_byte(CH_U);
        for (int i = 3; i >= 0; i--) begin
            send_byte(hex_char(value[i*4 +: 4]));
        end
    endtask

    // One random piece of a string body: mostly well formed, some broken.
    task automatic send_random_piece();
        int          pick;
        int          digits;
        logic [7:0]  b;
        pick = $urandom_range(99);
        if (pick < 45) begin
            do b = 8'($urandom_range(255));
            while (b == CH_QUOTE || b == CH_BACKSLASH);
            send_byte(b);
        end else if (pick < 60) begin
            send_byte(CH_BACKSLASH);
            send_byte(ESCAPE_LETTERS[$urandom_range(7)]);
        end else if (pick < 72) begin
            send_hex_escape(16'($urandom_range(16'h007F)));
        end else if (pick < 78) begin
            send_hex_escape(16'($urandom_range(16'hFFFF)));
        end else if (pick < 82) begin
            // Escape with an arbitrary letter, usually not a legal one.
            send_byte(CH_BACKSLASH);
            send_byte(8'($urandom_range(255)));
        end else if (pick < 86) begin
            // Unicode escape broken off by an arbitrary byte.
            digits = $urandom_range(3);
            send_byte(CH_BACKSLASH);
            send_byte(CH_U);
            repeat (digits) send_byte(hex_char(4'($urandom_range(15))));
            send_byte(8'($urandom_range(255)));
        end else if (pick < 90) begin
            // Stream end, sometimes in the middle of an escape.
            case ($urandom_range(2))
                0: ;
                1: send_byte(CH_BACKSLASH);
                default: begin
                    send_byte(CH_BACKSLASH);
                    send_byte(CH_U);
                    repeat ($urandom_range(3)) send_byte(hex_char(4'($urandom_range(15))));
                end
            endcase
            send_stream_end();
        end else begin
            send_byte(CH_QUOTE);
        end
    endtask

    // Run limit.
    initial begin
        #2000000;
        $display("json_string_unescape: mismatch");
        $finish;
    end

    // Reset, directed beats, three random phases, then drain.
    initial begin
        int wait_cycles;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_in_data    <= '0;
        i_out_stall  <= 1'b0;
        send_gap_pct = 22;
        stall_pct    = 85;
        beats_sent   = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: byte extremes, every simple escape, a non-ASCII unicode
        // escape, a stream end right after a backslash and a closing quote.
        send_byte(8'h00);
        send_byte(8'hFF);
        foreach (ESCAPE_LETTERS[i]) begin
            send_byte(CH_BACKSLASH);
            send_byte(ESCAPE_LETTERS[i]);
        end
        send_hex_escape(16'h00FA);
        send_byte(CH_BACKSLASH);
        send_stream_end();
        send_byte(CH_QUOTE);

        // Random phases with shifting idle patterns.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_gap_pct = 22; stall_pct = 85; end
                1: begin send_gap_pct = 85; stall_pct = 22; end
                default: begin send_gap_pct = 0; stall_pct = 0; end
            endcase
            while (beats_sent < 27 + 210 * (phase + 1)) send_random_piece();
        end
        i_in_valid <= 1'b0;

        // Drain the results still in flight.
        wait_cycles = 0;
        while (sb.expected_chars.size() != 0 && wait_cycles < 5000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (4) @(posedge i_clk);
        if (sb.expected_chars.size() != 0) begin
            $error("%0d expected result beats never arrived", sb.expected_chars.size());
            sb.failures++;
        end

        if (sb.failures == 0) begin
            $display("json_string_unescape: match");
        end else begin
            $display("json_string_unescape: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
rtl/core/jsu_pkg.sv
rtl/core/jsu_decode.sv
rtl/core/json_string_unescape.sv
sim/tb.sv
